// File: src/lcd_pkg.sv
// Package for the line command decoder: message kinds, byte codes, parse helpers.
// Used by lcd_front, lcd_back and line_command_decoder_unit. No dependencies.
package lcd_pkg;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_RESET   = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_BRAKE   = 3'd3,
      KIND_CMD     = 3'd4,
      KIND_UNKNOWN = 3'd5
   } kind_type;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;

   // front classification of a byte
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_LINE  = 2'd1,
      OP_OVER  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_WORD, ST_HEAD, ST_SKIP, ST_SIGN, ST_INT, ST_FRAC,
      ST_SCALE, ST_MUL, ST_DIV, ST_SAT, ST_DONE
   } state_type;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic [29:0] pow10(input logic [3:0] n);
      case (n)
         4'd0: pow10 = 30'd1;
         4'd1: pow10 = 30'd10;
         4'd2: pow10 = 30'd100;
         4'd3: pow10 = 30'd1000;
         4'd4: pow10 = 30'd10000;
         4'd5: pow10 = 30'd100000;
         4'd6: pow10 = 30'd1000000;
         4'd7: pow10 = 30'd10000000;
         4'd8: pow10 = 30'd100000000;
         4'd9: pow10 = 30'd1000000000;
         default: pow10 = 30'd1;
      endcase
   endfunction

endpackage

// File: src/lcd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: src/lcd_front.sv
// Front part: accepts bytes, writes the line store, counts length, queues line events.
// Depends on lcd_pkg.
module lcd_front #(
   parameter int LINE_BYTES = 64,
   localparam int AW = $clog2(LINE_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_byte,
   input  logic          back_busy,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          q_valid,
   input  logic          q_ready,
   output lcd_pkg::op_type q_op,
   output logic [AW-1:0] q_len
);
   logic [AW-1:0] len_ff, len_in;
   logic          qv_ff, qv_in;
   lcd_pkg::op_type qop_ff, qop_in;
   logic [AW-1:0] qlen_ff, qlen_in;
   logic          acc, is_lf, is_cr, full, walk;

   // one-entry queue; byte taken only when the queue can take its event
   // and no line walk reads the store
   assign walk     = back_busy || (qv_ff && qop_ff == lcd_pkg::OP_LINE);
   assign in_ready = (!qv_ff || q_ready) && !walk;
   assign acc      = in_valid && in_ready;
   assign is_lf    = in_byte == lcd_pkg::CH_LF;
   assign is_cr    = in_byte == lcd_pkg::CH_CR;
   assign full     = len_ff == AW'(LINE_BYTES - 1);
   assign wr_en    = acc && !is_lf && !is_cr && !full;
   assign wr_addr  = len_ff;
   assign wr_data  = in_byte;

   always_comb begin
      len_in  = len_ff;
      qv_in   = qv_ff && !q_ready;
      qop_in  = qop_ff;
      qlen_in = qlen_ff;
      if (acc) begin
         qv_in   = 1'b1;
         qlen_in = len_ff;
         qop_in  = lcd_pkg::OP_NONE;
         if (is_lf) begin
            qop_in = lcd_pkg::OP_LINE;
            len_in = '0;
         end else if (!is_cr) begin
            if (full) begin
               qop_in = lcd_pkg::OP_OVER;
               len_in = '0;
            end else begin
               len_in = len_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         len_ff <= len_in;
         qv_ff  <= qv_in;
      end
      qop_ff  <= qop_in;
      qlen_ff <= qlen_in;
   end

   assign q_valid = qv_ff;
   assign q_op    = qop_ff;
   assign q_len   = qlen_ff;
endmodule

// File: src/lcd_back.sv
// Back part: walks the stored line, matches words, parses two Q16.16 fields.
// Depends on lcd_pkg.
module lcd_back #(
   parameter int LINE_BYTES = 64,
   localparam int AW = $clog2(LINE_BYTES)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_ready,
   output logic            busy,
   input  lcd_pkg::op_type q_op,
   input  logic [AW-1:0]   q_len,
   output logic [AW-1:0]   rd_addr,
   input  logic [7:0]      rd_data,
   output logic            out_valid,
   input  logic            out_ready,
   output logic            out_accepted,
   output logic [2:0]      out_kind,
   output logic [31:0]     out_lin,
   output logic [31:0]     out_ang
);
   lcd_pkg::state_type st_ff, st_in;
   logic [AW-1:0] len_ff, len_in;      // line length, then text length
   logic [AW:0]   pos_ff, pos_in;      // read address issued
   logic          pend_ff, pend_in;    // rd_data valid for pos_ff-1
   logic          sec_ff, sec_in;      // parsing second field
   logic [AW-1:0] end_ff, end_in;      // end of current field
   logic [AW-1:0] comma_ff, comma_in;
   logic          cfound_ff, cfound_in;
   logic          mR_ff, mR_in, mS_ff, mS_in, mB_ff, mB_in, mC_ff, mC_in;
   logic          neg_ff, neg_in;
   logic [16:0]   ip_ff, ip_in;
   logic [29:0]   fv_ff, fv_in;
   logic [3:0]    nf_ff, nf_in;
   logic [45:0]   num_ff, num_in;      // fv * 65536, then remainder
   logic [29:0]   den_ff, den_in;
   logic [15:0]   quo_ff, quo_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [31:0]   lin_ff, lin_in, ang_ff, ang_in, tmp_ff, tmp_in;
   logic [31:0]   keep_ff, keep_in;    // first field until the second is done
   logic [2:0]    kind_ff, kind_in;
   logic          acc_ff, acc_in;
   logic          ov_ff, ov_in;
   logic [AW-1:0] idx;
   logic [7:0]    c;
   logic [33:0]   mag;
   logic [7:0]    ch_r [5];
   logic [7:0]    ch_s [4];
   logic [7:0]    ch_b [5];
   logic [7:0]    ch_c [4];

   assign ch_r = '{8'h52, 8'h45, 8'h53, 8'h45, 8'h54};
   assign ch_s = '{8'h53, 8'h54, 8'h4F, 8'h50};
   assign ch_b = '{8'h42, 8'h52, 8'h41, 8'h4B, 8'h45};
   assign ch_c = '{8'h43, 8'h4D, 8'h44, lcd_pkg::CH_COMMA};

   assign idx     = AW'(pos_ff - (AW + 1)'(1));
   assign c       = rd_data;
   // idle issues the read of the first byte
   assign rd_addr = (st_ff == lcd_pkg::ST_IDLE) ? '0 : pos_ff[AW-1:0];
   assign q_ready = (st_ff == lcd_pkg::ST_IDLE) && !ov_ff;
   assign busy    = st_ff != lcd_pkg::ST_IDLE;
   assign mag     = {1'b0, ip_ff, 16'd0} + {18'd0, quo_ff};

   always_comb begin
      st_in = st_ff; len_in = len_ff; pos_in = pos_ff; pend_in = 1'b0;
      sec_in = sec_ff; end_in = end_ff; comma_in = comma_ff; cfound_in = cfound_ff;
      mR_in = mR_ff; mS_in = mS_ff; mB_in = mB_ff; mC_in = mC_ff;
      neg_in = neg_ff; ip_in = ip_ff; fv_in = fv_ff; nf_in = nf_ff;
      num_in = num_ff; den_in = den_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      lin_in = lin_ff; ang_in = ang_ff; tmp_in = tmp_ff; kind_in = kind_ff;
      keep_in = keep_ff;
      acc_in = acc_ff; ov_in = ov_ff && !out_ready;
      case (st_ff)
         lcd_pkg::ST_IDLE: begin
            if (q_valid && q_ready) begin
               acc_in = 1'b0;
               if (q_op == lcd_pkg::OP_LINE) begin
                  len_in = q_len; pos_in = '0; pend_in = 1'b0;
                  mR_in = 1'b1; mS_in = 1'b1; mB_in = 1'b1; mC_in = 1'b1;
                  cfound_in = 1'b0;
                  st_in = lcd_pkg::ST_SCAN;
                  if (q_len == '0) st_in = lcd_pkg::ST_WORD;
                  else pos_in = (AW + 1)'(1);
                  pend_in = q_len != '0;
                  len_in  = q_len;
                  // length counted during scan; start from zero
                  end_in  = '0;
               end else begin
                  if (q_op == lcd_pkg::OP_OVER) kind_in = lcd_pkg::KIND_UNKNOWN;
                  ov_in = 1'b1;
               end
            end
         end
         lcd_pkg::ST_SCAN: begin
            // end_ff counts text length; byte idx arrives now
            if (c == 8'd0) begin
               st_in = lcd_pkg::ST_WORD;
            end else begin
               end_in = end_ff + AW'(1);
               if (idx < AW'(5)) begin
                  if (idx > AW'(4) || c != ch_r[idx[2:0]]) mR_in = 1'b0;
                  if (idx > AW'(4) || c != ch_b[idx[2:0]]) mB_in = 1'b0;
               end
               if (idx < AW'(4)) begin
                  if (c != ch_s[idx[1:0]]) mS_in = 1'b0;
                  if (c != ch_c[idx[1:0]]) mC_in = 1'b0;
               end else if (!cfound_ff && c == lcd_pkg::CH_COMMA) begin
                  cfound_in = 1'b1; comma_in = idx;
               end
               if (pos_ff[AW-1:0] == len_ff || pos_ff[AW]) begin
                  st_in = lcd_pkg::ST_WORD;
               end else begin
                  pos_in = pos_ff + (AW + 1)'(1);
               end
            end
         end
         lcd_pkg::ST_WORD: begin
            len_in = end_ff;
            st_in  = lcd_pkg::ST_DONE;
            acc_in = 1'b1;
            if (mR_ff && end_ff == AW'(5)) kind_in = lcd_pkg::KIND_RESET;
            else if (mS_ff && end_ff == AW'(4)) kind_in = lcd_pkg::KIND_STOP;
            else if (mB_ff && end_ff == AW'(5)) kind_in = lcd_pkg::KIND_BRAKE;
            else if (!mC_ff || end_ff < AW'(4) || !cfound_ff || comma_ff == AW'(4)
                     || (AW + 1)'(comma_ff) + (AW + 1)'(1) >= (AW + 1)'(end_ff)) begin
               kind_in = lcd_pkg::KIND_UNKNOWN; acc_in = 1'b0;
            end else begin
               sec_in = 1'b0; end_in = comma_ff;
               pos_in = (AW + 1)'(4);
               st_in  = lcd_pkg::ST_HEAD;
            end
         end
         lcd_pkg::ST_HEAD: begin
            neg_in = 1'b0; ip_in = '0; fv_in = '0; nf_in = '0;
            pos_in = pos_ff + (AW + 1)'(1); pend_in = 1'b1;
            st_in = lcd_pkg::ST_SKIP;
         end
         lcd_pkg::ST_SKIP, lcd_pkg::ST_SIGN, lcd_pkg::ST_INT, lcd_pkg::ST_FRAC: begin
            pos_in = pos_ff + (AW + 1)'(1); pend_in = 1'b1;
            if ((AW + 1)'(idx) >= (AW + 1)'(end_ff) || !pend_ff) begin
               st_in = lcd_pkg::ST_SCALE;
            end else if (st_ff == lcd_pkg::ST_SKIP && lcd_pkg::is_blank(c)) begin
               st_in = lcd_pkg::ST_SKIP;
            end else if ((st_ff == lcd_pkg::ST_SKIP) &&
                         (c == lcd_pkg::CH_PLUS || c == lcd_pkg::CH_MINUS)) begin
               neg_in = c == lcd_pkg::CH_MINUS;
               st_in = lcd_pkg::ST_INT;
            end else if (st_ff != lcd_pkg::ST_FRAC && lcd_pkg::is_digit(c)) begin
               if ({ip_ff, 3'd0} + {2'd0, ip_ff, 1'b0} + 20'(c[3:0]) > 20'd65536)
                  ip_in = 17'd65536;
               else
                  ip_in = 17'({ip_ff, 3'd0} + {2'd0, ip_ff, 1'b0} + 20'(c[3:0]));
               st_in = lcd_pkg::ST_INT;
            end else if (st_ff != lcd_pkg::ST_FRAC && c == lcd_pkg::CH_POINT) begin
               st_in = lcd_pkg::ST_FRAC;
            end else if (st_ff == lcd_pkg::ST_FRAC && lcd_pkg::is_digit(c)) begin
               if (nf_ff < 4'd9) begin
                  fv_in = {fv_ff[26:0], 3'd0} + {fv_ff[28:0], 1'b0} + 30'(c[3:0]);
                  nf_in = nf_ff + 4'd1;
               end
            end else begin
               st_in = lcd_pkg::ST_SCALE;
            end
         end
         lcd_pkg::ST_SCALE: begin
            num_in = {fv_ff, 16'd0};
            den_in = lcd_pkg::pow10(nf_ff);
            quo_in = '0; cnt_in = 5'd16;
            st_in = lcd_pkg::ST_DIV;
         end
         lcd_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle; quotient < 2^16
            if (cnt_ff == 5'd0) begin
               st_in = lcd_pkg::ST_SAT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
               den_in = den_ff;
               if (num_ff >= ({16'd0, den_ff} << (cnt_ff - 5'd1))) begin
                  num_in = num_ff - ({16'd0, den_ff} << (cnt_ff - 5'd1));
                  quo_in = quo_ff | (16'd1 << (cnt_ff - 5'd1));
               end
            end
         end
         lcd_pkg::ST_SAT: begin
            if (neg_ff) tmp_in = (mag > 34'h080000000) ? 32'h80000000 : 32'(34'd0 - mag);
            else tmp_in = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            st_in = lcd_pkg::ST_MUL;
         end
         lcd_pkg::ST_MUL: begin
            // both fields land together at end of second field
            if (!sec_ff) begin
               sec_in = 1'b1; end_in = len_ff;
               pos_in = (AW + 1)'(comma_ff) + (AW + 1)'(1);
               st_in  = lcd_pkg::ST_HEAD;
               keep_in = tmp_ff;
            end else begin
               lin_in  = keep_ff;
               ang_in  = tmp_ff;
               kind_in = lcd_pkg::KIND_CMD;
               st_in   = lcd_pkg::ST_DONE;
            end
         end
         lcd_pkg::ST_DONE: begin
            st_in = lcd_pkg::ST_IDLE;
            ov_in = 1'b1;
         end
         default: st_in = lcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= lcd_pkg::ST_IDLE; ov_ff <= 1'b0; kind_ff <= lcd_pkg::KIND_NONE;
         lin_ff <= '0; ang_ff <= '0; acc_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; kind_ff <= kind_in; acc_ff <= acc_in;
         lin_ff <= lin_in; ang_ff <= ang_in;
      end
      len_ff <= len_in; pos_ff <= pos_in; pend_ff <= pend_in; sec_ff <= sec_in;
      end_ff <= end_in; comma_ff <= comma_in; cfound_ff <= cfound_in;
      mR_ff <= mR_in; mS_ff <= mS_in; mB_ff <= mB_in; mC_ff <= mC_in;
      neg_ff <= neg_in; ip_ff <= ip_in; fv_ff <= fv_in; nf_ff <= nf_in;
      num_ff <= num_in; den_ff <= den_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      tmp_ff <= tmp_in; keep_ff <= keep_in;
   end

   assign out_valid    = ov_ff;
   assign out_accepted = acc_ff;
   assign out_kind     = kind_ff;
   assign out_lin      = lin_ff;
   assign out_ang      = ang_ff;
endmodule

// File: src/line_command_decoder_unit.sv
// Top level of the line command decoder: front, line store RAM, back.
// Depends on lcd_pkg, lcd_front, lcd_ram, lcd_back.
//
// Usage: received characters enter on req_ (one byte per transaction in
// req_tdata). Every accepted byte yields exactly one rsp_ transaction with
// the current status. Carriage returns are ignored; a newline decodes the
// stored line as RESET, STOP, BRAKE or CMD,<a>,<b> (two signed Q16.16
// velocities, truncated and saturated).
// An ordinary byte is answered through the front's event queue register and
// the back's result register. A newline walks the stored line once to find
// length and matches (one byte a cycle, up to LINE_BYTES-1), then walks each
// numeric field and runs a 16-step bit-serial fraction divider per field.
// The front takes one more byte while a result waits, through a one-entry
// event queue; while a newline is queued or walked req_tready stays low.
// A stalled receiver holds the result and, once the queue fills,
// req_tready falls. Reset clears length, kind and both velocities.
module line_command_decoder_unit #(
   parameter int LINE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] line_accepted, [3:1] message_kind, [35:4] linear_velocity,
   // [67:36] angular_velocity, [71:68] zero
   output logic [71:0] rsp_tdata
);
   localparam int AW = $clog2(LINE_BYTES);

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr, q_len;
   logic [7:0]      wr_data, rd_data;
   logic            q_valid, q_ready, acc, back_busy;
   lcd_pkg::op_type q_op;
   logic [2:0]      kind;
   logic [31:0]     lin, ang;

   lcd_front #(.LINE_BYTES(LINE_BYTES)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .back_busy, .wr_en, .wr_addr, .wr_data,
      .q_valid, .q_ready, .q_op, .q_len);

   lcd_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   lcd_back #(.LINE_BYTES(LINE_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_ready, .busy(back_busy), .q_op, .q_len,
      .rd_addr, .rd_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_accepted(acc),
      .out_kind(kind), .out_lin(lin), .out_ang(ang));

   assign rsp_tdata = {4'd0, ang, lin, kind, acc};

   a_acc_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3:1] != lcd_pkg::KIND_UNKNOWN
                                   && rsp_tdata[3:1] != lcd_pkg::KIND_NONE)
      else $error("accepted line with no known kind");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_kind_cmd: assert property (@(posedge clock) disable iff (reset)
      $changed(rsp_tdata[35:4]) && !$past(reset) |-> rsp_tdata[3:1] == lcd_pkg::KIND_CMD)
      else $error("velocity changed without command");
endmodule

// File: test/testbench.sv
// Testbench for line_command_decoder_unit: byte stream in, one status transaction per byte out.
// Depends on lcd_pkg and the RTL of the decoder; self-checking against an in-file line decoder.
`timescale 1ns / 1ps

class status_scoreboard;
   logic [71:0] pending[$];
   byte unsigned store[63];
   int unsigned length;
   lcd_pkg::kind_type kind;
   logic [31:0] linear;
   logic [31:0] angular;
   int errors;
   int checked;
   int accepted_lines;

   function new();
      length = 0;
      kind = lcd_pkg::KIND_NONE;
      linear = 0;
      angular = 0;
      errors = 0;
      checked = 0;
      accepted_lines = 0;
   endfunction

   function bit text_is(int unsigned n, string w);
      if (n != w.len()) return 0;
      for (int i = 0; i < w.len(); i++)
         if (store[i] != w[i]) return 0;
      return 1;
   endfunction

   function logic [31:0] parse_fixed(int unsigned p, int unsigned e);
      bit neg;
      longint unsigned ip, fv, mag, scale;
      int nf;
      neg = 0; ip = 0; fv = 0; nf = 0;
      while (p < e && lcd_pkg::is_blank(store[p])) p++;
      if (p < e && (store[p] == lcd_pkg::CH_PLUS || store[p] == lcd_pkg::CH_MINUS)) begin
         neg = store[p] == lcd_pkg::CH_MINUS;
         p++;
      end
      while (p < e && lcd_pkg::is_digit(store[p])) begin
         ip = ip * 10 + (store[p] - 8'h30);
         if (ip > 65536) ip = 65536;
         p++;
      end
      if (p < e && store[p] == lcd_pkg::CH_POINT) begin
         p++;
         while (p < e && lcd_pkg::is_digit(store[p])) begin
            if (nf < 9) begin
               fv = fv * 10 + (store[p] - 8'h30);
               nf++;
            end
            p++;
         end
      end
      scale = 1;
      for (int i = 0; i < nf; i++) scale = scale * 10;
      mag = ip * 65536 + (fv * 65536) / scale;
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return 32'(0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   function void decode_line();
      int unsigned n, comma;
      n = 0;
      while (n < length && store[n] != 0) n++;
      if (text_is(n, "RESET")) kind = lcd_pkg::KIND_RESET;
      else if (text_is(n, "STOP")) kind = lcd_pkg::KIND_STOP;
      else if (text_is(n, "BRAKE")) kind = lcd_pkg::KIND_BRAKE;
      else if (n < 4 || store[0] != "C" || store[1] != "M" || store[2] != "D" ||
               store[3] != lcd_pkg::CH_COMMA)
         kind = lcd_pkg::KIND_UNKNOWN;
      else begin
         comma = 4;
         while (comma < n && store[comma] != lcd_pkg::CH_COMMA) comma++;
         if (comma >= n || comma == 4 || comma + 1 >= n) kind = lcd_pkg::KIND_UNKNOWN;
         else begin
            linear = parse_fixed(4, comma);
            angular = parse_fixed(comma + 1, n);
            kind = lcd_pkg::KIND_CMD;
         end
      end
   endfunction

   function void note_byte(logic [7:0] b);
      logic acc;
      acc = 0;
      if (b == lcd_pkg::CH_LF) begin
         decode_line();
         length = 0;
         acc = kind != lcd_pkg::KIND_UNKNOWN && kind != lcd_pkg::KIND_NONE;
         if (acc) accepted_lines++;
      end else if (b != lcd_pkg::CH_CR) begin
         if (length >= 63) begin
            length = 0;
            kind = lcd_pkg::KIND_UNKNOWN;
         end else begin
            store[length] = b;
            length++;
         end
      end
      pending.push_back({4'b0, angular, linear, kind, acc});
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %0d: %s got %h want %h", checked, what, got, want);
   endtask

   task check_status(logic [71:0] got);
      logic [71:0] want;
      checked++;
      if (pending.size() == 0) begin
         report("unexpected transaction", got[31:0], 0);
         return;
      end
      want = pending.pop_front();
      if (got[0] !== want[0]) report("line_accepted", got[0], want[0]);
      if (got[3:1] !== want[3:1]) report("message_kind", got[3:1], want[3:1]);
      if (got[35:4] !== want[35:4]) report("linear_velocity", got[35:4], want[35:4]);
      if (got[67:36] !== want[67:36]) report("angular_velocity", got[67:36], want[67:36]);
      if (got[71:68] !== 4'b0) report("padding", got[71:68], 0);
   endtask
endclass

module testbench;
   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [71:0] rsp_tdata;

   status_scoreboard sb;
   int sent;
   bit hold_off;

   line_command_decoder_unit u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 90);
   endfunction

   task automatic send_byte(logic [7:0] b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
      sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function string rand_number();
      string s, d;
      int k;
      s = "";
      k = $urandom_range(0, 9);
      if (k == 0) s = " ";
      else if (k == 1) s = "\t ";
      k = $urandom_range(0, 3);
      if (k == 0) s = {s, "-"};
      else if (k == 1) s = {s, "+"};
      k = $urandom_range(0, 9) == 0 ? $urandom_range(5, 8) : $urandom_range(0, 3);
      for (int i = 0; i < k; i++) begin
         d.itoa($urandom_range(0, 9));
         s = {s, d};
      end
      if ($urandom_range(0, 2) != 0) begin
         s = {s, "."};
         k = $urandom_range(0, 4) == 0 ? $urandom_range(9, 12) : $urandom_range(0, 5);
         for (int i = 0; i < k; i++) begin
            d.itoa($urandom_range(0, 9));
            s = {s, d};
         end
      end
      if ($urandom_range(0, 15) == 0) s = {s, "x1"};
      return s;
   endfunction

   task automatic random_line();
      int k, n;
      k = $urandom_range(0, 99);
      if (k < 55) send_text({"CMD,", rand_number(), ",", rand_number()});
      else if (k < 62) send_text("RESET");
      else if (k < 68) send_text("STOP");
      else if (k < 74) send_text("BRAKE");
      else if (k < 78) send_text("CMD,1,");
      else if (k < 81) send_text("CMD,,2");
      else if (k < 84) send_text({"CMD,", rand_number(), "\r,", rand_number(), ",9"});
      else if (k < 87) send_text("ST\rOP");
      else if (k < 89) begin
         send_text("STOP");
         send_byte(8'h00);
         send_text("junk");
      end else begin
         n = $urandom_range(0, 99) < 10 ? $urandom_range(60, 70) : $urandom_range(0, 12);
         for (int i = 0; i < n; i++) send_byte($urandom_range(0, 255));
      end
      send_byte(lcd_pkg::CH_LF);
   endtask

   initial begin
      int g;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         g = $urandom_range(1, 20);
         repeat (g - 1) @(posedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);

   initial begin
      int w;
      sb = new();
      sent = 0;
      hold_off = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_text("RESET\n");
      send_text("STOP\r\n");
      send_text("BRAKE\n");
      send_text("CMD,1.5,-2.25\n");
      send_text("CMD,70000,-99999\n");
      send_text("CMD, -.0000153,+3.999999999999\n");
      send_text("HELLO\n");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(lcd_pkg::CH_LF);
      for (int i = 0; i < 64; i++) send_byte(8'h41);
      send_byte(lcd_pkg::CH_LF);
      send_text("CMD,-32768,32767.99999\n");
      hold_off = 1;
      for (int i = 0; i < 8; i++) send_text("CMD,1,1\n");
      while (sent < 1650) random_line();
      req_tvalid <= 0;
      w = 0;
      while (sb.pending.size() != 0 && w < 200000) begin
         @(posedge clock);
         w++;
      end
      repeat (300) @(posedge clock);
      $display("sent %0d bytes, checked %0d status transactions, %0d lines accepted",
               sent, sb.checked, sb.accepted_lines);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// File: files.f
src/lcd_pkg.sv
src/lcd_ram.sv
src/lcd_front.sv
src/lcd_back.sv
src/line_command_decoder_unit.sv
test/testbench.sv
